[hw/rtl/ll1pp_pkg.sv]
// shared types and constants for the ll1 predictive parse engine
// no dependencies
`timescale 1ns / 1ps

package ll1pp_pkg;

    localparam logic [2:0] FN_SET_CLASS = 3'd0;
    localparam logic [2:0] FN_SET_KIND  = 3'd1;
    localparam logic [2:0] FN_SET_RULE  = 3'd2;
    localparam logic [2:0] FN_BEGIN     = 3'd3;
    localparam logic [2:0] FN_FEED      = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_LIMIT  = 2'd3;

    localparam logic [1:0] CLS_TERM    = 2'd1;
    localparam logic [1:0] CLS_NONTERM = 2'd2;

    localparam logic [1:0] KIND_EPS  = 2'd1;
    localparam logic [1:0] KIND_RULE = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] symbol;
        logic [1:0] sym_class;
        logic [3:0] class_index;
        logic [3:0] row;
        logic [3:0] col;
        logic [1:0] entry_kind;
        logic [3:0] rhs_length;
        logic [2:0] rhs_position;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] stack_depth;
    } t_out_item;

    typedef enum logic [3:0] {
        DP_NONE, DP_CLEAR, DP_LOAD, DP_BEGIN, DP_TOKCAP, DP_TOP,
        DP_TOPCAP, DP_EVAL, DP_KIND, DP_PUSH, DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic go_begin;
        logic go_feed;
        logic sp_zero;
        logic eval_done;
        logic kind_fail;
        logic kind_len0;
        logic push_last;
        logic out_free;
    } t_dp_stat;

endpackage

[hw/rtl/ll1pp_ram.sv]
// generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module ll1pp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ll1pp_ctrl.sv]
// sequencing state machine of the parse engine
// depends on ll1pp_pkg
`timescale 1ns / 1ps

module ll1pp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ll1pp_pkg::t_dp_stat i_stat,
    output ll1pp_pkg::t_dp_cmd  o_cmd
);
    import ll1pp_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_BEGIN  = 10'b0000000100,
        S_TOKCAP = 10'b0000001000,
        S_TOP    = 10'b0000010000,
        S_TOPCAP = 10'b0000100000,
        S_EVAL   = 10'b0001000000,
        S_KIND   = 10'b0010000000,
        S_PUSH   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_dp_op w_op;

    always_comb begin
        n_state = r_state;
        w_op    = DP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                w_op = DP_CLEAR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op = DP_LOAD;
                    if (i_stat.go_begin)     n_state = S_BEGIN;
                    else if (i_stat.go_feed) n_state = S_TOKCAP;
                    else                     n_state = S_OUT;
                end
            end
            S_BEGIN: begin
                w_op    = DP_BEGIN;
                n_state = S_OUT;
            end
            S_TOKCAP: begin
                w_op    = DP_TOKCAP;
                n_state = S_TOP;
            end
            S_TOP: begin
                w_op    = DP_TOP;
                n_state = i_stat.sp_zero ? S_OUT : S_TOPCAP;
            end
            S_TOPCAP: begin
                w_op    = DP_TOPCAP;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                w_op    = DP_EVAL;
                n_state = i_stat.eval_done ? S_OUT : S_KIND;
            end
            S_KIND: begin
                w_op = DP_KIND;
                if (i_stat.kind_fail)      n_state = S_OUT;
                else if (i_stat.kind_len0) n_state = S_TOP;
                else                       n_state = S_PUSH;
            end
            S_PUSH: begin
                w_op = DP_PUSH;
                if (i_stat.push_last) n_state = S_TOP;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    w_op    = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.op   = w_op;

endmodule

[hw/rtl/ll1pp_dp.sv]
// datapath: symbol and table stores, parse stack, output register
// depends on ll1pp_pkg and ll1pp_ram
`timescale 1ns / 1ps

module ll1pp_dp #(
    parameter int NONTERM_MAX  = 16,
    parameter int TERM_MAX     = 16,
    parameter int RHS_MAX      = 8,
    parameter int STACK_DEPTH  = 64,
    parameter int EXPAND_LIMIT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ll1pp_pkg::t_dp_cmd   i_cmd,
    output ll1pp_pkg::t_dp_stat  o_stat,
    input  ll1pp_pkg::t_in_item  i_in,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ll1pp_pkg::t_out_item o_out
);
    import ll1pp_pkg::*;

    localparam int ENTRY_COUNT = NONTERM_MAX * TERM_MAX;
    localparam int EW   = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int RW   = (ENTRY_COUNT * RHS_MAX > 1) ? $clog2(ENTRY_COUNT * RHS_MAX) : 1;
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int PW   = (RHS_MAX > 1) ? $clog2(RHS_MAX) : 1;
    localparam int LENW = $clog2(RHS_MAX + 1);
    localparam int XW   = $clog2(EXPAND_LIMIT + 1);
    localparam int CLR_N = (ENTRY_COUNT > 256) ? ENTRY_COUNT : 256;
    localparam int CW   = $clog2(CLR_N);

    logic [7:0]       r_start, r_end, r_tok, r_top;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [1:0]       r_tcls, n_tcls;
    logic [3:0]       r_tidx, n_tidx;
    logic [EW-1:0]    r_ent, n_ent;
    logic [PW-1:0]    r_pos, n_pos;
    logic [XW-1:0]    r_exp, n_exp;
    logic [1:0]       r_phase, n_phase, r_final, n_final, r_res, n_res;
    logic [CW-1:0]    r_clr;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             cls_we, kind_we, rule_we, stk_we;
    logic [7:0]       cls_waddr, cls_raddr, stk_wdata, stk_rdata, rule_rdata;
    logic [5:0]       cls_wdata, cls_rdata, kind_wdata, kind_rdata;
    logic [EW-1:0]    kind_waddr, kind_raddr;
    logic [RW-1:0]    rule_waddr, rule_raddr;
    logic [SAW-1:0]   stk_waddr, stk_raddr;

    logic [11:0]      ent_in_w, ent_ev_w;
    logic             in_inside, clr_cls, clr_kind;
    logic             term_path, nt_bad;
    logic [LENW-1:0]  len_eff;
    logic [SPW+6:0]   need;

    assign ent_in_w  = 12'(i_in.row) * 12'(TERM_MAX) + 12'(i_in.col);
    assign ent_ev_w  = 12'(cls_rdata[5:2]) * 12'(TERM_MAX) + 12'(r_tidx);
    assign in_inside = (7'(i_in.row) < 7'(NONTERM_MAX)) && (7'(i_in.col) < 7'(TERM_MAX));
    assign clr_cls   = ({1'b0, r_clr} < (CW+1)'(256));
    assign clr_kind  = ({1'b0, r_clr} < (CW+1)'(ENTRY_COUNT));

    assign term_path = (r_top == r_end) || (cls_rdata[1:0] == CLS_TERM);
    assign nt_bad    = (cls_rdata[1:0] != CLS_NONTERM) || (r_tcls != CLS_TERM)
                     || (7'(cls_rdata[5:2]) >= 7'(NONTERM_MAX))
                     || (7'(r_tidx) >= 7'(TERM_MAX));

    always_comb begin
        if (kind_rdata[1:0] != KIND_RULE) begin
            len_eff = '0;
        end else if (6'(kind_rdata[5:2]) > 6'(RHS_MAX)) begin
            len_eff = LENW'(RHS_MAX);
        end else begin
            len_eff = LENW'(kind_rdata[5:2]);
        end
    end
    assign need = (SPW+7)'(r_sp) - (SPW+7)'(1) + (SPW+7)'(len_eff);

    always_comb begin
        n_sp = r_sp; n_tcls = r_tcls; n_tidx = r_tidx; n_ent = r_ent;
        n_pos = r_pos; n_exp = r_exp; n_phase = r_phase; n_final = r_final;
        n_res = r_res;
        cls_we = 1'b0; cls_waddr = i_in.symbol;
        cls_wdata = {i_in.class_index, i_in.sym_class};
        cls_raddr = i_in.symbol;
        kind_we = 1'b0; kind_waddr = EW'(ent_in_w);
        kind_wdata = {i_in.rhs_length, i_in.entry_kind};
        kind_raddr = EW'(ent_ev_w);
        rule_we = 1'b0;
        rule_waddr = RW'(EW'(ent_in_w)) * RW'(RHS_MAX) + RW'(i_in.rhs_position);
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = r_end;
        stk_raddr = SAW'(r_sp - SPW'(1));
        o_stat = '0;
        o_stat.clr_done  = (r_clr == CW'(CLR_N - 1));
        o_stat.go_begin  = (i_in.func == FN_BEGIN);
        o_stat.go_feed   = (i_in.func == FN_FEED) && (r_phase == PH_RUN);
        o_stat.sp_zero   = (r_sp == '0);
        o_stat.eval_done = term_path || nt_bad;
        o_stat.kind_fail = (kind_rdata[1:0] != KIND_EPS && kind_rdata[1:0] != KIND_RULE)
                         || (r_exp >= XW'(EXPAND_LIMIT))
                         || (need > (SPW+7)'(STACK_DEPTH));
        o_stat.kind_len0 = (len_eff == '0);
        o_stat.push_last = (r_pos == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;

        case (i_cmd.op)
            DP_CLEAR: begin
                cls_we = clr_cls; cls_waddr = r_clr[7:0]; cls_wdata = '0;
                kind_we = clr_kind; kind_waddr = EW'(r_clr); kind_wdata = '0;
            end
            DP_LOAD: begin
                n_exp = '0;
                n_res = ST_OK;
                case (i_in.func)
                    FN_SET_CLASS: cls_we = 1'b1;
                    FN_SET_KIND:  kind_we = in_inside;
                    FN_SET_RULE:  rule_we = in_inside
                                          && (6'(i_in.rhs_position) < 6'(RHS_MAX));
                    FN_BEGIN:     stk_we = 1'b1;
                    FN_FEED: begin
                        if (r_phase == PH_DONE)      n_res = r_final;
                        else if (r_phase == PH_IDLE) n_res = ST_REJECT;
                    end
                    default: ;
                endcase
            end
            DP_BEGIN: begin
                stk_we = 1'b1; stk_waddr = SAW'(1); stk_wdata = r_start;
                n_sp = SPW'(2); n_phase = PH_RUN; n_final = ST_OK; n_res = ST_OK;
            end
            DP_TOKCAP: begin
                n_tcls = cls_rdata[1:0]; n_tidx = cls_rdata[5:2];
            end
            DP_TOP: begin
                if (r_sp == '0) begin
                    n_res = ST_REJECT; n_final = ST_REJECT; n_phase = PH_DONE;
                end
            end
            DP_TOPCAP: cls_raddr = stk_rdata;
            DP_EVAL: begin
                n_ent = EW'(ent_ev_w);
                if (term_path) begin
                    if (r_top != r_tok) begin
                        n_res = ST_REJECT; n_final = ST_REJECT; n_phase = PH_DONE;
                    end else begin
                        n_sp = r_sp - SPW'(1);
                        if (r_tok == r_end) begin
                            n_res = (r_sp == SPW'(1)) ? ST_ACCEPT : ST_REJECT;
                            n_final = n_res; n_phase = PH_DONE;
                        end else begin
                            n_res = ST_OK;
                        end
                    end
                end else if (nt_bad) begin
                    n_res = ST_REJECT; n_final = ST_REJECT; n_phase = PH_DONE;
                end
            end
            DP_KIND: begin
                if (kind_rdata[1:0] != KIND_EPS && kind_rdata[1:0] != KIND_RULE) begin
                    n_res = ST_REJECT; n_final = ST_REJECT; n_phase = PH_DONE;
                end else if (r_exp >= XW'(EXPAND_LIMIT)
                             || need > (SPW+7)'(STACK_DEPTH)) begin
                    n_res = ST_LIMIT; n_final = ST_LIMIT; n_phase = PH_DONE;
                end else begin
                    n_exp = r_exp + XW'(1);
                    n_sp = r_sp - SPW'(1);
                    n_pos = PW'(len_eff - LENW'(1));
                end
            end
            DP_PUSH: begin
                stk_we = 1'b1; stk_waddr = SAW'(r_sp); stk_wdata = rule_rdata;
                n_sp = r_sp + SPW'(1);
                n_pos = r_pos - PW'(1);
            end
            default: ;
        endcase
        rule_raddr = RW'(r_ent) * RW'(RHS_MAX) + RW'(n_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 8'd83; r_end <= 8'd36;
            r_sp <= '0; r_phase <= PH_IDLE; r_final <= ST_OK; r_res <= ST_OK;
            r_exp <= '0; r_clr <= '0; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_START) r_start <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_END)   r_end   <= i_cfg_data;
            r_sp <= n_sp; r_phase <= n_phase; r_final <= n_final;
            r_res <= n_res; r_exp <= n_exp;
            if (i_cmd.op == DP_CLEAR) r_clr <= r_clr + CW'(1);
            if (i_cmd.op == DP_EMIT)  r_out_valid <= 1'b1;
            else if (i_out_ready)     r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tcls <= n_tcls; r_tidx <= n_tidx; r_ent <= n_ent; r_pos <= n_pos;
        if (i_cmd.op == DP_LOAD)   r_tok <= i_in.symbol;
        if (i_cmd.op == DP_TOPCAP) r_top <= stk_rdata;
        if (i_cmd.op == DP_EMIT) begin
            r_out.status      <= r_res;
            r_out.stack_depth <= 7'(r_sp);
        end
    end

    ll1pp_ram #(.WIDTH(6), .DEPTH(256)) u_cls (
        .i_clk(i_clk), .i_we(cls_we), .i_waddr(cls_waddr), .i_wdata(cls_wdata),
        .i_raddr(cls_raddr), .o_rdata(cls_rdata)
    );

    ll1pp_ram #(.WIDTH(6), .DEPTH(ENTRY_COUNT), .AW(EW)) u_kind (
        .i_clk(i_clk), .i_we(kind_we), .i_waddr(kind_waddr), .i_wdata(kind_wdata),
        .i_raddr(kind_raddr), .o_rdata(kind_rdata)
    );

    ll1pp_ram #(.WIDTH(8), .DEPTH(ENTRY_COUNT * RHS_MAX), .AW(RW)) u_rule (
        .i_clk(i_clk), .i_we(rule_we), .i_waddr(rule_waddr), .i_wdata(i_in.symbol),
        .i_raddr(rule_raddr), .o_rdata(rule_rdata)
    );

    ll1pp_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hw/rtl/ll1_predictive_parse_engine.sv]
// a token in a running parse is matched against the stack top or expands a nonterminal,
// each expansion pushing its rule symbols one by one; a full output register stalls the engine;
// one item at a time; the stack loop and its stack and table reads set the rate
// synchronous active-low reset; after reset a clearing pass empties the symbol class and
// table kind stores before the first item is taken
// configuration writes are taken at any time; depends on ll1pp_pkg, ll1pp_ctrl, ll1pp_dp
`timescale 1ns / 1ps

module ll1_predictive_parse_engine #(
    parameter int NONTERM_MAX  = 16,
    parameter int TERM_MAX     = 16,
    parameter int RHS_MAX      = 8,
    parameter int STACK_DEPTH  = 64,
    parameter int EXPAND_LIMIT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ll1pp_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ll1pp_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);
    import ll1pp_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ll1pp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    ll1pp_dp #(
        .NONTERM_MAX(NONTERM_MAX), .TERM_MAX(TERM_MAX), .RHS_MAX(RHS_MAX),
        .STACK_DEPTH(STACK_DEPTH), .EXPAND_LIMIT(EXPAND_LIMIT)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_in(i_in_data), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready), .o_out(o_out_data)
    );

endmodule

[test/ll1_predictive_parse_engine_test.sv]
// self-checking testbench for ll1_predictive_parse_engine: directed cases, then random
// grammars with guided token streams, checked against a behavioral predictor
// depends on ll1pp_pkg and the ll1_predictive_parse_engine rtl
`timescale 1ns / 1ps

module ll1_predictive_parse_engine_test;
    import ll1pp_pkg::*;

    localparam int NT_MAX     = 16;
    localparam int T_MAX      = 16;
    localparam int RULE_MAX   = 8;
    localparam int STK_MAX    = 64;
    localparam int EXP_MAX    = 64;
    localparam int IDLE_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    ll1_predictive_parse_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // parser shadow state
    logic [7:0] start_sym;
    logic [7:0] end_sym;
    logic [5:0] class_mem [256];
    logic [5:0] entry_mem [256];
    logic [7:0] rhs_mem [2048];
    bit         rhs_set [2048];
    logic [7:0] pstack [STK_MAX];
    int         depth;
    logic [1:0] phase;
    logic [1:0] kept_status;

    t_out_item  result_q [$];
    int         fail_count;
    int         send_gap_pct;
    int         recv_gap_pct;
    int         quiet_cycles;

    logic [7:0] nt_syms [$];
    logic [7:0] t_syms [$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [1:0] close_parse(logic [1:0] st);
        phase = PH_DONE;
        kept_status = st;
        return st;
    endfunction

    function automatic logic [1:0] consume_token(logic [7:0] tok);
        int         expansions;
        int         len;
        int         e;
        logic [7:0] top;
        logic [1:0] tcls;
        logic [3:0] tidx;
        logic [1:0] kind;
        expansions = 0;
        while (1) begin
            if (depth == 0) return close_parse(ST_REJECT);
            top = pstack[depth - 1];
            if (top == end_sym || class_mem[top][1:0] == CLS_TERM) begin
                if (top != tok) return close_parse(ST_REJECT);
                depth--;
                if (tok == end_sym) return close_parse(depth == 0 ? ST_ACCEPT : ST_REJECT);
                return ST_OK;
            end
            if (class_mem[top][1:0] != CLS_NONTERM) return close_parse(ST_REJECT);
            tcls = class_mem[tok][1:0];
            tidx = class_mem[tok][5:2];
            if (tcls != CLS_TERM || class_mem[top][5:2] >= NT_MAX || tidx >= T_MAX)
                return close_parse(ST_REJECT);
            e = class_mem[top][5:2] * T_MAX + tidx;
            kind = entry_mem[e][1:0];
            if (kind != KIND_EPS && kind != KIND_RULE) return close_parse(ST_REJECT);
            if (expansions >= EXP_MAX) return close_parse(ST_LIMIT);
            expansions++;
            len = (kind == KIND_RULE) ? entry_mem[e][5:2] : 0;
            if (len > RULE_MAX) len = RULE_MAX;
            if (depth - 1 + len > STK_MAX) return close_parse(ST_LIMIT);
            depth--;
            for (int i = len; i > 0; i--) begin
                pstack[depth] = rhs_mem[e * RULE_MAX + i - 1];
                depth++;
            end
        end
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        int        e;
        r.status = ST_OK;
        e = it.row * T_MAX + it.col;
        case (it.func)
            FN_SET_CLASS: class_mem[it.symbol] = {it.class_index, it.sym_class};
            FN_SET_KIND:  entry_mem[e] = {it.rhs_length, it.entry_kind};
            FN_SET_RULE: begin
                rhs_mem[e * RULE_MAX + it.rhs_position] = it.symbol;
                rhs_set[e * RULE_MAX + it.rhs_position] = 1'b1;
            end
            FN_BEGIN: begin
                pstack[0] = end_sym;
                pstack[1] = start_sym;
                depth = 2;
                phase = PH_RUN;
                kept_status = ST_OK;
            end
            FN_FEED: begin
                if (phase == PH_RUN) r.status = consume_token(it.symbol);
                else if (phase == PH_DONE) r.status = kept_status;
                else r.status = ST_REJECT;
            end
            default: ;
        endcase
        r.stack_depth = depth[6:0];
        return r;
    endfunction

    // result checker and output stalls
    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = result_q.pop_front();
                if (o_out_data.status !== want.status) begin
                    $display("%0t status expected %0d actual %0d", $time, want.status,
                             o_out_data.status);
                    fail_count++;
                end
                if (o_out_data.stack_depth !== want.stack_depth) begin
                    $display("%0t depth expected %0d actual %0d", $time, want.stack_depth,
                             o_out_data.stack_depth);
                    fail_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_gap_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        result_q = {result_q, predict_result(it)};
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] s, logic [7:0] m);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_END;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        start_sym = s;
        end_sym   = m;
    endtask

    function automatic t_in_item rand_item(logic [2:0] f);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        it.func = f;
        return it;
    endfunction

    function automatic logic [7:0] pool_symbol();
        int n;
        n = $urandom_range(0, 99);
        if (n < 5 || (nt_syms.size() == 0 && t_syms.size() == 0))
            return 8'($urandom_range(0, 255));
        if (n < 10) return end_sym;
        if (n < 50 && nt_syms.size() != 0) return nt_syms[$urandom_range(0, nt_syms.size() - 1)];
        if (t_syms.size() != 0) return t_syms[$urandom_range(0, t_syms.size() - 1)];
        return nt_syms[0];
    endfunction

    task automatic send_class(logic [7:0] s, logic [1:0] c, logic [3:0] idx);
        t_in_item it;
        it = rand_item(FN_SET_CLASS);
        it.symbol = s;
        it.sym_class = c;
        it.class_index = idx;
        send_item(it);
    endtask

    task automatic send_rule_sym(logic [3:0] r, logic [3:0] c, logic [2:0] pos, logic [7:0] s);
        t_in_item it;
        it = rand_item(FN_SET_RULE);
        it.row = r;
        it.col = c;
        it.rhs_position = pos;
        it.symbol = s;
        send_item(it);
    endtask

    // rule symbols that the new length would read are written first if never set
    task automatic send_kind(logic [3:0] r, logic [3:0] c, logic [1:0] k, logic [3:0] len);
        t_in_item it;
        int       e;
        e = r * T_MAX + c;
        if (k == KIND_RULE)
            for (int p = 0; p < len && p < RULE_MAX; p++)
                if (!rhs_set[e * RULE_MAX + p]) send_rule_sym(r, c, 3'(p), pool_symbol());
        it = rand_item(FN_SET_KIND);
        it.row = r;
        it.col = c;
        it.entry_kind = k;
        it.rhs_length = len;
        send_item(it);
    endtask

    task automatic send_begin;
        send_item(rand_item(FN_BEGIN));
    endtask

    task automatic send_token(logic [7:0] tok);
        t_in_item it;
        it = rand_item(FN_FEED);
        it.symbol = tok;
        send_item(it);
    endtask

    task automatic send_noise;
        t_in_item it;
        it = rand_item(3'($urandom_range(0, 7)));
        if (it.func == FN_SET_KIND)
            send_kind(it.row, it.col, it.entry_kind, it.rhs_length);
        else
            send_item(it);
    endtask

    task automatic test_directed;
        send_token(8'd97);
        send_item(rand_item(3'd5));
        send_item(rand_item(3'd6));
        send_item(rand_item(3'd7));
        send_class(8'd83, CLS_NONTERM, 4'd0);
        send_class(8'd97, CLS_TERM, 4'd0);
        send_class(8'd36, CLS_TERM, 4'd1);
        send_class(8'd99, CLS_TERM, 4'd2);
        send_class(8'd66, CLS_NONTERM, 4'd15);
        send_class(8'd255, 2'd3, 4'd15);
        send_rule_sym(4'd0, 4'd0, 3'd0, 8'd97);
        send_rule_sym(4'd0, 4'd0, 3'd1, 8'd66);
        send_kind(4'd0, 4'd0, KIND_RULE, 4'd2);
        send_kind(4'd15, 4'd1, KIND_EPS, 4'd0);
        send_kind(4'd15, 4'd0, 2'd3, 4'd15);
        send_kind(4'd0, 4'd1, KIND_RULE, 4'd0);
        send_rule_sym(4'd0, 4'd2, 3'd0, 8'd120);
        send_kind(4'd0, 4'd2, KIND_RULE, 4'd1);
        for (int p = 0; p < RULE_MAX; p++) send_rule_sym(4'd15, 4'd2, 3'(p), 8'd99);
        send_kind(4'd15, 4'd2, KIND_RULE, 4'd15);
        send_rule_sym(4'd15, 4'd15, 3'd7, 8'd0);
        // match then epsilon then end marker
        send_begin;
        send_token(8'd97);
        send_token(8'd36);
        send_token(8'd97);
        // empty rule
        send_begin;
        send_token(8'd36);
        // error entry of kind three, then declared-undeclared token
        send_begin;
        send_token(8'd97);
        send_token(8'd97);
        send_begin;
        send_token(8'd255);
        // undeclared symbol on top
        send_begin;
        send_token(8'd99);
        // long rule clipped to the maximum
        send_begin;
        send_token(8'd97);
        send_token(8'd99);
        send_token(8'd99);
        send_token(8'd36);
        drain;
    endtask

    task automatic build_grammar;
        bit         used [256];
        logic [7:0] s;
        int         nt_n;
        int         t_n;
        int         n;
        nt_syms.delete();
        t_syms.delete();
        foreach (used[i]) used[i] = 1'b0;
        used[start_sym] = 1'b1;
        used[end_sym] = 1'b1;
        nt_n = $urandom_range(1, 4);
        t_n  = $urandom_range(1, 4);
        nt_syms = {nt_syms, start_sym};
        while (nt_syms.size() < nt_n || t_syms.size() < t_n) begin
            s = 8'($urandom_range(0, 255));
            if (!used[s]) begin
                used[s] = 1'b1;
                if (nt_syms.size() < nt_n) nt_syms = {nt_syms, s};
                else t_syms = {t_syms, s};
            end
        end
        foreach (nt_syms[i]) send_class(nt_syms[i], CLS_NONTERM, 4'(i));
        foreach (t_syms[i]) send_class(t_syms[i], CLS_TERM, 4'(i));
        send_class(end_sym, CLS_TERM, 4'(t_n));
        for (int r = 0; r < nt_n; r++)
            for (int c = 0; c <= t_n; c++) begin
                n = $urandom_range(0, 99);
                if (n < 15) send_kind(4'(r), 4'(c), 2'd0, 4'($urandom_range(0, 15)));
                else if (n < 45) send_kind(4'(r), 4'(c), KIND_EPS, 4'($urandom_range(0, 15)));
                else begin
                    n = ($urandom_range(0, 99) < 4) ? $urandom_range(9, 15)
                                                    : $urandom_range(0, 3);
                    for (int p = 0; p < n && p < RULE_MAX; p++)
                        send_rule_sym(4'(r), 4'(c), 3'(p), pool_symbol());
                    send_kind(4'(r), 4'(c), KIND_RULE, 4'(n));
                end
            end
    endtask

    function automatic logic [7:0] pick_token();
        logic [7:0] top;
        int         n;
        top = pstack[depth - 1];
        n = $urandom_range(0, 99);
        if ((top == end_sym || class_mem[top][1:0] == CLS_TERM) && n < 90) return top;
        if (n < 3) return 8'($urandom_range(0, 255));
        if (n < 15 || t_syms.size() == 0) return end_sym;
        return t_syms[$urandom_range(0, t_syms.size() - 1)];
    endfunction

    task automatic test_parse_phase(logic [7:0] s, logic [7:0] m, int items);
        int sent;
        int toks;
        write_regs(s, m);
        build_grammar;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 99) < 8) begin
                send_noise;
                sent++;
            end else begin
                send_begin;
                toks = 0;
                while (phase == PH_RUN && depth != 0) begin
                    send_token(toks < 30 ? pick_token() : end_sym);
                    toks++;
                end
                if ($urandom_range(0, 3) == 0) send_token(pool_symbol());
                sent += toks + 1;
            end
        end
        drain;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_START;
        i_cfg_data   = '0;
        fail_count   = 0;
        quiet_cycles = 0;
        start_sym    = 8'd83;
        end_sym      = 8'd36;
        depth        = 0;
        phase        = PH_IDLE;
        kept_status  = ST_OK;
        foreach (class_mem[i]) class_mem[i] = '0;
        foreach (entry_mem[i]) entry_mem[i] = '0;
        foreach (rhs_set[i]) rhs_set[i] = 1'b0;
        send_gap_pct = 23;
        recv_gap_pct = 49;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed;
        test_parse_phase(8'd0, 8'd255, 150);
        test_parse_phase(8'd255, 8'd0, 150);
        send_gap_pct = 49;
        recv_gap_pct = 23;
        test_parse_phase(8'($urandom_range(1, 127)), 8'($urandom_range(128, 254)), 150);
        test_parse_phase(8'd83, 8'd36, 150);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_parse_phase(8'd1, 8'd2, 150);
        test_parse_phase(8'($urandom_range(128, 254)), 8'($urandom_range(1, 127)), 150);
        drain;
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
